// ===== rtl/fcau_pkg.sv =====
// Shared types and constants of the FAT cluster address unit.
package fcau_pkg;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } fat_kind_e;

  typedef enum logic [2:0] {
    REG_BPS    = 3'd0,
    REG_SPC    = 3'd1,
    REG_RSV    = 3'd2,
    REG_COPIES = 3'd3,
    REG_SPF    = 3'd4,
    REG_ROOT   = 3'd5,
    REG_VOL    = 3'd6,
    REG_HIDDEN = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_LOAD,
    DV_DIV,
    DV_BASE,
    DV_KIND
  } derive_state_e;

  // FAT type thresholds and entry markers
  localparam logic [11:0] Fat16MinClusters = 12'd4085;
  localparam logic [15:0] Fat32MinClusters = 16'd65525;
  localparam logic [27:0] EndMark12  = 28'h0000FF8;
  localparam logic [27:0] EndMark16  = 28'h000FFF8;
  localparam logic [27:0] EndMark32  = 28'h FFFFFF8;
  localparam logic [27:0] BadMark12  = 28'h0000FF7;
  localparam logic [27:0] BadMark16  = 28'h000FFF7;
  localparam logic [27:0] BadMark32  = 28'h FFFFFF7;

  // Geometry seen by the datapath
  typedef struct packed {
    logic [12:0] bps;
    logic [7:0]  spc;
    logic [15:0] rsv;
    logic [31:0] hidden;
    logic [31:0] base;
    fat_kind_e   kind;
    logic        busy;
  } cfg_t;

  // Classified item waiting for the divider
  typedef struct packed {
    fat_kind_e   kind;
    logic [31:0] offset;
    logic [27:0] next;
    logic        chain_end;
    logic        bad;
    logic [31:0] dsec;
    logic        oor;
  } entry_t;

endpackage

// ===== rtl/fcau_if.sv =====
// Valid/ready channel interfaces for lookup requests and results.
interface fcau_in_if;
  logic        valid;
  logic        ready;
  logic [27:0] cluster;
  logic [7:0]  sector_index;
  logic [31:0] fat_raw;
  modport source (output valid, cluster, sector_index, fat_raw, input ready);
  modport sink (input valid, cluster, sector_index, fat_raw, output ready);
endinterface

interface fcau_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  fat_kind;
  logic [31:0] fat_sector;
  logic [11:0] fat_byte_offset;
  logic [27:0] next_cluster;
  logic        chain_end;
  logic        cluster_bad;
  logic [31:0] data_sector;
  logic        index_out_of_range;
  modport source (output valid, fat_kind, fat_sector, fat_byte_offset, next_cluster,
                  chain_end, cluster_bad, data_sector, index_out_of_range, input ready);
  modport sink (input valid, fat_kind, fat_sector, fat_byte_offset, next_cluster,
                chain_end, cluster_bad, data_sector, index_out_of_range, output ready);
endinterface

// ===== rtl/fcau_cfg.sv =====
// Configuration registers and geometry derivation sequencer.
module fcau_cfg import fcau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [12:0] bps_q;
  logic [7:0]  spc_q;
  logic [15:0] rsv_q;
  logic [2:0]  copies_q;
  logic [31:0] spf_q;
  logic [15:0] root_ent_q;
  logic [31:0] vol_q;
  logic [31:0] hidden_q;

  logic [15:0] root_q, root_d;
  logic [31:0] base_q, base_d;
  logic [34:0] base_full_q, base_full_d;
  fat_kind_e   kind_q, kind_d;
  derive_state_e st_q, st_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [21:0] dnum_q, dnum_d;
  logic [12:0] drem_q, drem_d;

  logic       wr;
  reg_idx_e   idx;
  logic [13:0] t;
  logic [32:0] dsecs;
  logic [19:0] lim16;
  logic [23:0] lim32;

  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bps_q      <= 13'd512;
      spc_q      <= 8'd1;
      rsv_q      <= 16'd1;
      copies_q   <= 3'd2;
      spf_q      <= 32'd9;
      root_ent_q <= 16'd224;
      vol_q      <= 32'd2880;
      hidden_q   <= 32'd0;
    end else if (wr) begin
      unique case (idx)
        REG_BPS:    bps_q      <= pwdata[12:0];
        REG_SPC:    spc_q      <= pwdata[7:0];
        REG_RSV:    rsv_q      <= pwdata[15:0];
        REG_COPIES: copies_q   <= pwdata[2:0];
        REG_SPF:    spf_q      <= pwdata;
        REG_ROOT:   root_ent_q <= pwdata[15:0];
        REG_VOL:    vol_q      <= pwdata;
        REG_HIDDEN: hidden_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_BPS:    prdata = {19'd0, bps_q};
      REG_SPC:    prdata = {24'd0, spc_q};
      REG_RSV:    prdata = {16'd0, rsv_q};
      REG_COPIES: prdata = {29'd0, copies_q};
      REG_SPF:    prdata = spf_q;
      REG_ROOT:   prdata = {16'd0, root_ent_q};
      REG_VOL:    prdata = vol_q;
      REG_HIDDEN: prdata = hidden_q;
      default:    prdata = 32'd0;
    endcase
  end

  // derivation state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= DV_IDLE;
      root_q      <= 16'd14;
      base_q      <= 32'd33;
      base_full_q <= 35'd33;
      kind_q      <= KIND_FAT12;
      dcnt_q      <= 5'd0;
      dnum_q      <= 22'd0;
      drem_q      <= 13'd0;
    end else begin
      st_q        <= st_d;
      root_q      <= root_d;
      base_q      <= base_d;
      base_full_q <= base_full_d;
      kind_q      <= kind_d;
      dcnt_q      <= dcnt_d;
      dnum_q      <= dnum_d;
      drem_q      <= drem_d;
    end
  end

  // root size division (one bit a cycle), then base, then FAT type
  always_comb begin
    st_d        = st_q;
    root_d      = root_q;
    base_d      = base_q;
    base_full_d = base_full_q;
    kind_d      = kind_q;
    dcnt_d      = dcnt_q;
    dnum_d      = dnum_q;
    drem_d      = drem_q;
    t           = {drem_q, dnum_q[21]};
    dsecs       = ({1'b0, vol_q} > base_full_q[32:0] && base_full_q[34:33] == 2'd0) ?
                  ({1'b0, vol_q} - base_full_q[32:0]) : 33'd0;
    lim16       = 20'(spc_q) * 20'(Fat16MinClusters);
    lim32       = 24'(spc_q) * 24'(Fat32MinClusters);
    unique case (st_q)
      DV_IDLE: ;
      DV_LOAD: begin
        dnum_d = {1'b0, root_ent_q, 5'd0} + {9'd0, bps_q} - 22'd1;
        drem_d = 13'd0;
        dcnt_d = 5'd0;
        st_d   = DV_DIV;
      end
      DV_DIV: begin
        dnum_d = {dnum_q[20:0], 1'b0};
        if (t >= {1'b0, bps_q}) begin
          drem_d    = 13'(t - {1'b0, bps_q});
          dnum_d[0] = 1'b1;
        end else begin
          drem_d = t[12:0];
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd21) st_d = DV_BASE;
      end
      DV_BASE: begin
        if (bps_q == 13'd0) root_d = 16'd0;
        else if (dnum_q[21:16] != 6'd0) root_d = 16'hFFFF;
        else root_d = dnum_q[15:0];
        base_full_d = {19'd0, rsv_q} + 35'(copies_q) * 35'(spf_q) + {19'd0, root_d};
        base_d      = base_full_d[31:0];
        st_d        = DV_KIND;
      end
      DV_KIND: begin
        if (spc_q == 8'd0 || dsecs < 33'(lim16)) kind_d = KIND_FAT12;
        else if (dsecs < 33'(lim32)) kind_d = KIND_FAT16;
        else kind_d = KIND_FAT32;
        st_d = DV_IDLE;
      end
      default: st_d = DV_IDLE;
    endcase
    if (wr) st_d = DV_LOAD;
  end

  assign cfg_o = '{bps: bps_q, spc: spc_q, rsv: rsv_q, hidden: hidden_q, base: base_q,
                   kind: kind_q, busy: (st_q != DV_IDLE)};

endmodule

// ===== rtl/fcau_front.sv =====
// Front end: accepts items, decodes the FAT entry and forms the data sector.
module fcau_front import fcau_pkg::*; (
  fcau_in_if.sink in_ch,
  input  cfg_t    cfg_i,
  input  logic    q_full_i,
  output logic    push_o,
  output entry_t  entry_o
);

  logic [31:0] cl;
  logic [15:0] w;
  logic [31:0] prod;

  assign in_ch.ready = !cfg_i.busy && !q_full_i;
  assign push_o      = in_ch.valid && in_ch.ready;
  assign cl          = {4'd0, in_ch.cluster};
  assign w           = in_ch.fat_raw[15:0];
  assign prod        = (cl - 32'd2) * {24'd0, cfg_i.spc};

  // classify by FAT type
  always_comb begin
    entry_o.kind = cfg_i.kind;
    case (cfg_i.kind)
      KIND_FAT12: begin
        entry_o.offset    = cl + (cl >> 1);
        entry_o.next      = in_ch.cluster[0] ? {16'd0, w[15:4]} : {16'd0, w[11:0]};
        entry_o.chain_end = entry_o.next >= EndMark12;
        entry_o.bad       = entry_o.next == BadMark12;
      end
      KIND_FAT16: begin
        entry_o.offset    = {cl[30:0], 1'b0};
        entry_o.next      = {12'd0, w};
        entry_o.chain_end = entry_o.next >= EndMark16;
        entry_o.bad       = entry_o.next == BadMark16;
      end
      default: begin
        entry_o.offset    = {cl[29:0], 2'b00};
        entry_o.next      = in_ch.fat_raw[27:0];
        entry_o.chain_end = entry_o.next >= EndMark32;
        entry_o.bad       = entry_o.next == BadMark32;
      end
    endcase
    entry_o.oor  = in_ch.sector_index >= cfg_i.spc;
    entry_o.dsec = entry_o.oor ? 32'd0 :
                   cfg_i.hidden + cfg_i.base + prod + {24'd0, in_ch.sector_index};
  end

endmodule

// ===== rtl/fcau_queue.sv =====
// Short FIFO between front end and divider back end.
module fcau_queue import fcau_pkg::*; #(
  parameter int Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t data_i,
  input  logic   pop_i,
  output entry_t data_o,
  output logic   valid_o,
  output logic   full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == CntW'(Depth);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/fcau_back.sv =====
// Back end: divides the entry offset by the sector size, 8 bits a cycle while the output is not held.
module fcau_back import fcau_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  entry_t entry_i,
  input  logic   q_valid_i,
  output logic   pop_o,
  fcau_out_if.source out_ch
);

  logic        busy_q;
  logic [1:0]  cnt_q;
  logic [31:0] dvd_q;
  logic [12:0] rem_q;
  entry_t      ent_q;
  logic        ov_q;

  logic [31:0] d;
  logic [12:0] r;
  logic [13:0] t;
  logic        last, xfer, step;

  // eight restoring division steps
  always_comb begin
    d = dvd_q;
    r = rem_q;
    t = '0;
    for (int i = 0; i < 8; i++) begin
      t = {r, d[31]};
      d = {d[30:0], 1'b0};
      if (t >= {1'b0, cfg_i.bps}) begin
        r    = 13'(t - {1'b0, cfg_i.bps});
        d[0] = 1'b1;
      end else begin
        r = t[12:0];
      end
    end
  end

  assign last  = busy_q && cnt_q == 2'd3;
  assign xfer  = last && (!ov_q || out_ch.ready);
  assign step  = busy_q && (!last || xfer);
  assign pop_o = q_valid_i && (!busy_q || xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
      ov_q   <= 1'b0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= 2'd0;
      end else if (xfer) begin
        busy_q <= 1'b0;
      end else if (step) begin
        cnt_q <= cnt_q + 2'd1;
      end
      if (xfer) ov_q <= 1'b1;
      else if (out_ch.ready) ov_q <= 1'b0;
    end
  end

  // divider datapath and output register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= entry_i;
      dvd_q <= entry_i.offset;
      rem_q <= 13'd0;
    end else if (step) begin
      dvd_q <= d;
      rem_q <= r;
    end
    if (xfer) begin
      out_ch.fat_kind           <= ent_q.kind;
      out_ch.fat_sector         <= {16'd0, cfg_i.rsv} +
                                   ((cfg_i.bps == 13'd0) ? 32'd0 : d);
      out_ch.fat_byte_offset    <= (cfg_i.bps == 13'd0) ? 12'd0 : r[11:0];
      out_ch.next_cluster       <= ent_q.next;
      out_ch.chain_end          <= ent_q.chain_end;
      out_ch.cluster_bad        <= ent_q.bad;
      out_ch.data_sector        <= ent_q.dsec;
      out_ch.index_out_of_range <= ent_q.oor;
    end
  end

  assign out_ch.valid = ov_q;

endmodule

// ===== rtl/fat_cluster_address_unit.sv =====
// FAT cluster address unit: an accepted item passes through the queue, the offset divider
// and the output register; the divider takes its next item as it hands the last result on,
// and retires 8 quotient bits a cycle while the output is not held. Reset loads the default
// floppy geometry with its derived values ready at once. After each register write the input
// is held not ready while the root size, data base and FAT type are rederived.
module fat_cluster_address_unit import fcau_pkg::*; #(
  parameter int QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcau_in_if.sink     in_ch,
  fcau_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t   cfg;
  entry_t f_entry, q_entry;
  logic   push, pop, q_valid, q_full;

  fcau_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  fcau_front u_front (
    .in_ch, .cfg_i(cfg), .q_full_i(q_full), .push_o(push), .entry_o(f_entry)
  );

  fcau_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(f_entry), .pop_i(pop),
    .data_o(q_entry), .valid_o(q_valid), .full_o(q_full)
  );

  fcau_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .entry_i(q_entry), .q_valid_i(q_valid),
    .pop_o(pop), .out_ch
  );

endmodule

// ===== test/tb_fat_cluster_address_unit.sv =====
// Testbench for the FAT cluster address unit: scoreboarded lookups over several geometries.
`timescale 1ns / 100ps

module tb_fat_cluster_address_unit import fcau_pkg::*; ();

  localparam int StallLimit = 4000;

  // One expected lookup result
  typedef struct {
    fat_kind_e   kind;
    logic [31:0] fat_sector;
    logic [11:0] byte_offset;
    logic [27:0] next_cluster;
    logic        chain_end;
    logic        bad;
    logic [31:0] data_sector;
    logic        oor;
  } lookup_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  fcau_in_if  in_ch ();
  fcau_out_if out_ch ();

  fat_cluster_address_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch.sink),
    .out_ch  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Geometry copy and derived values
  logic [12:0] geo_bps;
  logic [7:0]  geo_spc;
  logic [15:0] geo_rsv;
  logic [2:0]  geo_copies;
  logic [31:0] geo_spf;
  logic [15:0] geo_root;
  logic [31:0] geo_vol;
  logic [31:0] geo_hidden;
  fat_kind_e   dv_kind;
  logic [31:0] dv_base;

  lookup_t     pending_lookups[$];
  int          error_count;
  bit          idle_en;
  int          hold_left;
  int          burst_left;
  int          quiet_cycles;

  // Clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rederive root size, data base and FAT type
  task automatic derive_geometry();
    logic [63:0] root;
    logic [63:0] base;
    logic [63:0] data_secs;
    logic [63:0] clusters;
    begin
      root = 0;
      data_secs = 0;
      clusters = 0;
      if (geo_bps != 0) root = (64'(geo_root) * 32 + geo_bps - 1) / geo_bps;
      if (root > 64'hFFFF) root = 64'hFFFF;
      base = 64'(geo_rsv) + 64'(geo_copies) * 64'(geo_spf) + root;
      dv_base = base[31:0];
      if (64'(geo_vol) > base) data_secs = 64'(geo_vol) - base;
      if (geo_spc != 0) clusters = data_secs / geo_spc;
      if (clusters < 4085) dv_kind = KIND_FAT12;
      else if (clusters < 65525) dv_kind = KIND_FAT16;
      else dv_kind = KIND_FAT32;
    end
  endtask

  function automatic lookup_t predict_lookup(logic [27:0] cl, logic [7:0] sidx,
                                             logic [31:0] raw);
    lookup_t     r;
    logic [31:0] offset;
    logic [31:0] quot;
    logic [31:0] rem;
    logic [15:0] w;
    begin
      quot = 0;
      rem = 0;
      case (dv_kind)
        KIND_FAT12: offset = {4'd0, cl} + {5'd0, cl[27:1]};
        KIND_FAT16: offset = {3'd0, cl, 1'b0};
        default:    offset = {2'd0, cl, 2'b0};
      endcase
      if (geo_bps != 0) begin
        quot = offset / geo_bps;
        rem = offset % geo_bps;
      end
      w = raw[15:0];
      case (dv_kind)
        KIND_FAT12: begin
          r.next_cluster = cl[0] ? 28'(w >> 4) : 28'(w & 16'h0FFF);
          r.chain_end = r.next_cluster >= EndMark12;
          r.bad = r.next_cluster == BadMark12;
        end
        KIND_FAT16: begin
          r.next_cluster = 28'(w);
          r.chain_end = r.next_cluster >= EndMark16;
          r.bad = r.next_cluster == BadMark16;
        end
        default: begin
          r.next_cluster = raw[27:0];
          r.chain_end = r.next_cluster >= EndMark32;
          r.bad = r.next_cluster == BadMark32;
        end
      endcase
      r.kind = dv_kind;
      r.fat_sector = 32'(geo_rsv) + quot;
      r.byte_offset = rem[11:0];
      r.oor = sidx >= geo_spc;
      r.data_sector = 0;
      if (!r.oor)
        r.data_sector = geo_hidden + dv_base + ({4'd0, cl} - 32'd2) * 32'(geo_spc) + 32'(sidx);
      return r;
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    begin
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", field, got, want, $realtime);
      error_count++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    lookup_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_lookups.size() == 0) begin
        $display("unexpected result item at %0t", $realtime);
        error_count++;
      end else begin
        e = pending_lookups.pop_front();
        if (out_ch.fat_kind !== e.kind) report_mismatch("fat_kind", out_ch.fat_kind, e.kind);
        if (out_ch.fat_sector !== e.fat_sector)
          report_mismatch("fat_sector", out_ch.fat_sector, e.fat_sector);
        if (out_ch.fat_byte_offset !== e.byte_offset)
          report_mismatch("fat_byte_offset", out_ch.fat_byte_offset, e.byte_offset);
        if (out_ch.next_cluster !== e.next_cluster)
          report_mismatch("next_cluster", out_ch.next_cluster, e.next_cluster);
        if (out_ch.chain_end !== e.chain_end)
          report_mismatch("chain_end", out_ch.chain_end, e.chain_end);
        if (out_ch.cluster_bad !== e.bad) report_mismatch("cluster_bad", out_ch.cluster_bad, e.bad);
        if (out_ch.data_sector !== e.data_sector)
          report_mismatch("data_sector", out_ch.data_sector, e.data_sector);
        if (out_ch.index_out_of_range !== e.oor)
          report_mismatch("index_out_of_range", out_ch.index_out_of_range, e.oor);
      end
    end
  end

  // Receiver: long hold, random stall bursts
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready = 1'b0;
    end else if (burst_left > 0) begin
      burst_left--;
      out_ch.ready = 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(0, 3);
      out_ch.ready = 1'b0;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("** fat_cluster_address_unit: FAILED **");
      $finish;
    end
  end

  // Send one lookup item; expectation is queued on acceptance
  task automatic send_lookup(logic [27:0] cl, logic [7:0] sidx, logic [31:0] raw);
    int gap;
    begin
      @(negedge clk_i);
      in_ch.valid = 1'b1;
      in_ch.cluster = cl;
      in_ch.sector_index = sidx;
      in_ch.fat_raw = raw;
      do @(posedge clk_i); while (!in_ch.ready);
      pending_lookups.push_back(predict_lookup(cl, sidx, raw));
      if (idle_en && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 4);
        repeat (gap) begin
          @(negedge clk_i);
          in_ch.valid = 1'b0;
        end
      end
    end
  endtask

  task automatic wait_drained();
    begin
      @(negedge clk_i);
      in_ch.valid = 1'b0;
      while (pending_lookups.size() != 0) @(posedge clk_i);
      repeat (12) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    begin
      @(negedge clk_i);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = {idx, 2'b00};
      pwdata = value;
      @(negedge clk_i);
      penable = 1'b1;
      do @(posedge clk_i); while (!pready);
      case (idx)
        REG_BPS:    geo_bps = value[12:0];
        REG_SPC:    geo_spc = value[7:0];
        REG_RSV:    geo_rsv = value[15:0];
        REG_COPIES: geo_copies = value[2:0];
        REG_SPF:    geo_spf = value;
        REG_ROOT:   geo_root = value[15:0];
        REG_VOL:    geo_vol = value;
        default:    geo_hidden = value;
      endcase
      derive_geometry();
      @(negedge clk_i);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
    end
  endtask

  task automatic write_geometry(logic [31:0] bps, logic [31:0] spc, logic [31:0] rsv,
                                logic [31:0] copies, logic [31:0] spf, logic [31:0] root,
                                logic [31:0] vol, logic [31:0] hidden);
    begin
      wait_drained();
      write_reg(REG_BPS, bps);
      write_reg(REG_SPC, spc);
      write_reg(REG_RSV, rsv);
      write_reg(REG_COPIES, copies);
      write_reg(REG_SPF, spf);
      write_reg(REG_ROOT, root);
      write_reg(REG_VOL, vol);
      write_reg(REG_HIDDEN, hidden);
    end
  endtask

  // Random lookup shaped so markers, boundary clusters and valid indexes are common
  task automatic send_random_lookup();
    logic [27:0] cl;
    logic [7:0]  sidx;
    logic [31:0] raw;
    logic [15:0] mark;
    begin
      case ($urandom_range(0, 3))
        0: cl = 28'($urandom_range(0, 3));
        1: cl = 28'($urandom_range(0, 5000));
        2: cl = 28'hFFFFFFF - 28'($urandom_range(0, 3));
        default: cl = 28'($urandom);
      endcase
      if (geo_spc != 0 && $urandom_range(0, 4) != 0) sidx = 8'($urandom_range(0, geo_spc - 1));
      else sidx = 8'($urandom);
      raw = $urandom;
      if ($urandom_range(0, 2) == 0) begin
        case (dv_kind)
          KIND_FAT12: begin
            mark = $urandom_range(0, 1) ? 16'h0FF7 : 16'(16'h0FF8 + $urandom_range(0, 7));
            raw[15:0] = cl[0] ? {mark[11:0], 4'($urandom)} : {4'($urandom), mark[11:0]};
          end
          KIND_FAT16: raw[15:0] = $urandom_range(0, 1) ? 16'hFFF7 :
                                  16'(16'hFFF8 + $urandom_range(0, 7));
          default: raw[27:0] = $urandom_range(0, 1) ? 28'hFFFFFF7 :
                               28'(28'hFFFFFF8 + $urandom_range(0, 7));
        endcase
      end
      send_lookup(cl, sidx, raw);
    end
  endtask

  // Default floppy geometry straight after reset
  task automatic test_reset_geometry();
    begin
      send_lookup(28'd0, 8'd0, 32'h00000000);
      send_lookup(28'd1, 8'd0, 32'hFFFFFFFF);
      send_lookup(28'd2, 8'd0, 32'h00000FF7);
      send_lookup(28'd3, 8'd1, 32'h0000FF80);
      send_lookup(28'hFFFFFFF, 8'hFF, 32'h12345678);
    end
  endtask

  // One lookup set each for a FAT16 and a FAT32 geometry
  task automatic test_fat_kinds();
    begin
      write_geometry(512, 4, 1, 2, 200, 512, 200000, 63);
      send_lookup(28'd2, 8'd3, 32'h0000FFF7);
      send_lookup(28'd255, 8'd4, 32'hABCDFFF8);
      send_lookup(28'd257, 8'd0, 32'h00001234);
      write_geometry(4096, 8, 32, 4, 4000, 0, 4000000, 32'hFFFFFFFF);
      send_lookup(28'd2, 8'd7, 32'hFFFFFFF7);
      send_lookup(28'd1025, 8'd0, 32'hF0FFFFF8);
      send_lookup(28'hFFFFFFF, 8'd8, 32'h0ABCDEF0);
    end
  endtask

  // Zero sector size, zero cluster size, root saturation, oversized geometry
  task automatic test_geometry_extremes();
    begin
      write_geometry(0, 0, 65535, 7, 32'hFFFFFFFF, 65535, 0, 0);
      send_lookup(28'd5, 8'd0, 32'h0000FFFF);
      send_lookup(28'd6, 8'd0, 32'h00000FF8);
      write_geometry(1, 128, 0, 1, 1, 65535, 32'hFFFFFFFF, 32'h80000000);
      send_lookup(28'd0, 8'd127, 32'h00000000);
      send_lookup(28'd1, 8'd128, 32'hFFFFFFFF);
      send_lookup(28'hFFFFFFF, 8'd0, 32'h55555555);
      write_geometry(8191, 255, 0, 0, 0, 0, 32'hFFFFFFFF, 1);
      send_lookup(28'h8000000, 8'd254, 32'hAAAAAAAA);
      send_lookup(28'h7FFFFFF, 8'd255, 32'h0FFFFFF7);
    end
  endtask

  // Receiver holds off while items keep coming, then sender waits for a full drain and sends more
  task automatic test_backpressure();
    begin
      write_geometry(512, 4, 1, 2, 200, 512, 200000, 0);
      @(negedge clk_i);
      hold_left = 80;
      repeat (20) send_random_lookup();
      wait_drained();
      repeat (20) send_random_lookup();
    end
  endtask

  task automatic test_random_geometries();
    int phase;
    logic [31:0] bps;
    begin
      for (phase = 0; phase < 6; phase++) begin
        bps = 32'(512 << $urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) bps = $urandom;
        write_geometry(bps, $urandom_range(0, 3) == 0 ? $urandom : 1 << $urandom_range(0, 7),
                       $urandom_range(0, 64), $urandom_range(1, 4),
                       $urandom_range(0, 1) ? $urandom_range(1, 300) : $urandom_range(1, 20000),
                       $urandom_range(0, 1) ? 0 : $urandom_range(0, 1024),
                       $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(1000, 8000000),
                       $urandom);
        if (phase == 5) idle_en = 1'b0;
        repeat (110) send_random_lookup();
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cluster = '0;
    in_ch.sector_index = '0;
    in_ch.fat_raw = '0;
    out_ch.ready = 1'b0;
    error_count = 0;
    idle_en = 1'b1;
    hold_left = 0;
    burst_left = 0;
    quiet_cycles = 0;
    geo_bps = 512;
    geo_spc = 1;
    geo_rsv = 1;
    geo_copies = 2;
    geo_spf = 9;
    geo_root = 224;
    geo_vol = 2880;
    geo_hidden = 0;
    derive_geometry();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_geometry();
    test_fat_kinds();
    test_geometry_extremes();
    test_backpressure();
    test_random_geometries();
    wait_drained();
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("** fat_cluster_address_unit: PASSED **");
    end else begin
      $display("** fat_cluster_address_unit: FAILED **");
    end
    $finish;
  end

endmodule
